// ===== rtl/bdac_pkg.sv =====
// Shared types, codes and constants of the backlight dimming controller.
// Holds the build-time lux-to-brightness table function. No dependencies.
`default_nettype none

package bdac_pkg;

	// Parameter defaults for the top level
	localparam int unsigned LUX_ROM_DEPTH_DEF     = 1024;
	localparam int unsigned AMBIENT_PERIOD_MS_DEF = 1000;
	localparam int unsigned MAX_SLEW_DEF          = 4;

	// Lux mapping limits and brightness constants
	localparam int unsigned LUX_LOW         = 1;
	localparam int unsigned LUX_HIGH        = 1000;
	localparam logic [7:0]  BRI_LOW         = 8'd20;
	localparam logic [7:0]  BRI_HIGH        = 8'd255;
	localparam logic [7:0]  UNDIM_FLOOR     = 8'd50;
	localparam logic [15:0] FADE_DEFAULT_MS = 16'd30;
	localparam int unsigned MS_PER_S        = 1000;
	localparam int unsigned LOG_FRAC_BITS   = 32;

	// Timeout in ms: 65535 s * 1000 fits in 26 bits
	localparam int unsigned DIM_MS_W = 26;

	// Register reset values
	localparam logic        AUTO_ENABLE_RST      = 1'b0;
	localparam logic [15:0] FADE_STEP_RST        = 16'd30;
	localparam logic [7:0]  START_BRIGHTNESS_RST = 8'd255;
	localparam logic [7:0]  BRIGHT_RST           = 8'd255;
	localparam logic [7:0]  SAVED_RST            = 8'd255;

	// Configuration register indexes
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] CFG_AUTO_ENABLE      = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DIM_TIMEOUT_S    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_FADE_STEP_MS     = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_START_BRIGHTNESS = 2'd3;

	typedef enum logic [1:0] {
		OP_POLL     = 2'd0,
		OP_ACTIVITY = 2'd1,
		OP_INIT     = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		MODE_AWAKE     = 2'd0,
		MODE_DIMMING   = 2'd1,
		MODE_UNDIMMING = 2'd2
	} mode_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] now_ms;
		logic        lux_valid;
		logic [15:0] lux;
	} item_t;

	typedef struct packed {
		logic [7:0] level;
		logic       level_written;
		logic [1:0] mode_now;
		logic       dimmed;
	} result_t;

	// log2(x) with 32 fraction bits, truncated, by repeated squaring
	function automatic logic [63:0] log2_fixed(input logic [31:0] x);
		logic [63:0] m;
		logic [63:0] r;
		int          n;
		int          j;
		int          i;
		n = 0;
		for (j = 0; j < 12; j++) begin
			if ((x >> (j + 1)) != 32'd0)
				n = j + 1;
		end
		m = ({32'd0, x} << 31) >> n;
		r = 64'(n) << LOG_FRAC_BITS;
		for (i = 31; i >= 0; i--) begin
			m = (m * m) >> 31;
			if (m >= 64'h1_0000_0000) begin
				m = m >> 1;
				r[i] = 1'b1;
			end
		end
		return r;
	endfunction

	// Table entry: 20 + floor(235 * log10(i) / 3), clamped at both ends
	function automatic logic [7:0] lux_entry(input int unsigned idx);
		logic [63:0] num;
		logic [63:0] den;
		logic [7:0]  k;
		int          j;
		k = 8'd0;
		if (idx <= LUX_LOW)
			return BRI_LOW;
		if (idx >= LUX_HIGH)
			return BRI_HIGH;
		num = 64'(BRI_HIGH - BRI_LOW) * log2_fixed(32'(idx));
		den = 64'd3 * log2_fixed(32'd10);
		// largest k with k * den <= num
		for (j = 1; j <= 235; j++) begin
			if (64'(j) * den <= num)
				k = 8'(j);
		end
		return BRI_LOW + k;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/bdac_in_if.sv =====
// Input channel of the backlight dimming controller: valid/ready plus one item word.
// Depends on bdac_pkg for the item type.
`default_nettype none

interface bdac_in_if;
	logic                 valid;
	logic                 ready;
	bdac_pkg::item_t      data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/bdac_out_if.sv =====
// Result channel of the backlight dimming controller: valid/ready plus one result word.
// Depends on bdac_pkg for the result type.
`default_nettype none

interface bdac_out_if;
	logic                 valid;
	logic                 ready;
	bdac_pkg::result_t    data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/backlight_dim_ambient_controller.sv =====
// Backlight dimming / ambient brightness controller, top level.
// Depends on bdac_pkg, bdac_in_if and bdac_out_if.
//
// Takes one word per cycle while the result side is not stalling and returns one
// result word per item. The first stage registers the item and reads the lux
// table (a ROM filled at build time); the second stage updates the mode,
// brightness and timer state in a single pass and registers the result.
// Throughput is one item per clock unless the receiver holds off; the
// result register lets a new word enter while a finished result waits.
// Timestamps are compared modulo 2^32. Config writes are taken any cycle but
// are meant to happen only while the block is idle.
`default_nettype none

module backlight_dim_ambient_controller #(
	parameter int unsigned LUX_ROM_DEPTH     = bdac_pkg::LUX_ROM_DEPTH_DEF,
	parameter int unsigned AMBIENT_PERIOD_MS = bdac_pkg::AMBIENT_PERIOD_MS_DEF,
	parameter int unsigned MAX_SLEW          = bdac_pkg::MAX_SLEW_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [bdac_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [bdac_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	bdac_in_if.sink                               item,
	bdac_out_if.source                            result
);

	localparam int unsigned ROM_AW = $clog2(LUX_ROM_DEPTH);

	// Lux table, constant contents
	logic [7:0] lux_rom [LUX_ROM_DEPTH];

	for (genvar gi = 0; gi < LUX_ROM_DEPTH; gi++) begin : g_rom
		localparam logic [7:0] ENTRY = bdac_pkg::lux_entry(gi);
		assign lux_rom[gi] = ENTRY;
	end

	// Configuration registers
	logic                          auto_en_q;
	logic [bdac_pkg::DIM_MS_W-1:0] dim_ms_q;
	logic [15:0]                   fade_step_q;
	logic [7:0]                    start_bri_q;

	// Controller state
	bdac_pkg::mode_t mode_q, mode_nxt;
	logic [7:0]      bright_q, bright_nxt;
	logic [7:0]      saved_q, saved_nxt;
	logic [7:0]      goal_q, goal_nxt;
	logic            dim_q, dim_nxt;
	logic [31:0]     act_time_q, act_time_nxt;
	logic [31:0]     fade_time_q, fade_time_nxt;
	logic            fade_vld_q, fade_vld_nxt;
	logic [31:0]     amb_time_q, amb_time_nxt;
	logic            amb_vld_q, amb_vld_nxt;
	logic            wrote;

	// Stage 1: registered item and table read
	logic        vld_s1;
	logic [1:0]  op_s1;
	logic [31:0] now_s1;
	logic        luxv_s1;
	logic        lux_lo_s1;
	logic        lux_hi_s1;
	logic [7:0]  rom_s1;

	// Stage 2: result register
	logic              vld_s2;
	bdac_pkg::result_t res_s2;
	bdac_pkg::result_t res_nxt;

	logic advance;
	logic retire;

	// Handshake
	assign advance      = !vld_s2 || result.ready;
	assign item.ready   = !vld_s1 || advance;
	assign retire       = vld_s1 && advance;
	assign result.valid = vld_s2;
	assign result.data  = res_s2;

	// Timer differences and lux target
	logic [31:0] act_dt;
	logic [31:0] fade_dt;
	logic [31:0] amb_dt;
	logic        fade_due_raw;
	logic        amb_due;
	logic [7:0]  tgt;
	logic [7:0]  delta_up;
	logic [7:0]  delta_dn;
	logic [7:0]  slew;
	logic [7:0]  step_up;
	logic [7:0]  step_dn;

	assign act_dt       = now_s1 - act_time_q;
	assign fade_dt      = now_s1 - fade_time_q;
	assign amb_dt       = now_s1 - amb_time_q;
	assign fade_due_raw = !fade_vld_q || (fade_dt >= {16'd0, fade_step_q});
	assign amb_due      = !amb_vld_q || (amb_dt >= 32'(AMBIENT_PERIOD_MS));
	assign tgt          = lux_lo_s1 ? bdac_pkg::BRI_LOW :
	                      lux_hi_s1 ? bdac_pkg::BRI_HIGH : rom_s1;
	assign delta_up     = tgt - bright_q;
	assign delta_dn     = bright_q - tgt;
	assign slew         = 8'(MAX_SLEW);
	assign step_up      = (delta_up < slew) ? delta_up : slew;
	assign step_dn      = (delta_dn < slew) ? delta_dn : slew;

	// Next state
	always_comb begin
		mode_nxt      = mode_q;
		bright_nxt    = bright_q;
		saved_nxt     = saved_q;
		goal_nxt      = goal_q;
		dim_nxt       = dim_q;
		act_time_nxt  = act_time_q;
		fade_time_nxt = fade_time_q;
		fade_vld_nxt  = fade_vld_q;
		amb_time_nxt  = amb_time_q;
		amb_vld_nxt   = amb_vld_q;
		wrote         = 1'b0;
		case (op_s1)
			bdac_pkg::OP_INIT: begin
				wrote        = (bright_q != start_bri_q);
				bright_nxt   = start_bri_q;
				saved_nxt    = start_bri_q;
				goal_nxt     = 8'd0;
				dim_nxt      = 1'b0;
				mode_nxt     = bdac_pkg::MODE_AWAKE;
				act_time_nxt = now_s1;
				fade_vld_nxt = 1'b0;
				amb_vld_nxt  = 1'b0;
			end
			bdac_pkg::OP_ACTIVITY: begin
				act_time_nxt = now_s1;
				// wake a dimmed or dark display
				if (dim_q || bright_q == 8'd0) begin
					dim_nxt      = 1'b0;
					fade_vld_nxt = 1'b0;
					goal_nxt     = (saved_q != 8'd0) ? saved_q : bdac_pkg::UNDIM_FLOOR;
					mode_nxt     = bdac_pkg::MODE_UNDIMMING;
				end
			end
			bdac_pkg::OP_POLL: begin
				case (mode_q)
					bdac_pkg::MODE_DIMMING: begin
						// first poll in dimming latches the level and restarts the step timer
						if (!dim_q) begin
							dim_nxt   = 1'b1;
							saved_nxt = bright_q;
						end
						if (!dim_q || fade_due_raw) begin
							fade_vld_nxt  = 1'b1;
							fade_time_nxt = now_s1;
							if (bright_q != 8'd0) begin
								bright_nxt = bright_q - 8'd1;
								wrote      = 1'b1;
							end
						end
						if (bright_nxt == 8'd0)
							mode_nxt = bdac_pkg::MODE_AWAKE;
					end
					bdac_pkg::MODE_UNDIMMING: begin
						if (fade_due_raw) begin
							fade_vld_nxt  = 1'b1;
							fade_time_nxt = now_s1;
							if (bright_q < goal_q) begin
								bright_nxt = bright_q + 8'd1;
								wrote      = 1'b1;
							end
						end
						if (bright_nxt >= goal_q)
							mode_nxt = bdac_pkg::MODE_AWAKE;
					end
					default: begin
						// awake: inactivity timeout, else ambient glide
						if (!dim_q && dim_ms_q != '0 &&
						    act_dt >= 32'(dim_ms_q)) begin
							mode_nxt = bdac_pkg::MODE_DIMMING;
						end else if (auto_en_q && !dim_q && amb_due) begin
							amb_vld_nxt  = 1'b1;
							amb_time_nxt = now_s1;
							if (luxv_s1 && tgt != bright_q) begin
								bright_nxt = (tgt > bright_q) ? bright_q + step_up
								                              : bright_q - step_dn;
								saved_nxt  = bright_nxt;
								wrote      = 1'b1;
							end
						end
					end
				endcase
			end
			default: ;
		endcase
	end

	// Result word
	always_comb begin
		res_nxt.level         = bright_nxt;
		res_nxt.level_written = wrote;
		res_nxt.mode_now      = mode_nxt;
		res_nxt.dimmed        = dim_nxt;
	end

	// Control, state and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			auto_en_q   <= bdac_pkg::AUTO_ENABLE_RST;
			dim_ms_q    <= '0;
			fade_step_q <= bdac_pkg::FADE_STEP_RST;
			start_bri_q <= bdac_pkg::START_BRIGHTNESS_RST;
			mode_q      <= bdac_pkg::MODE_AWAKE;
			bright_q    <= bdac_pkg::BRIGHT_RST;
			saved_q     <= bdac_pkg::SAVED_RST;
			goal_q      <= 8'd0;
			dim_q       <= 1'b0;
			act_time_q  <= 32'd0;
			fade_time_q <= 32'd0;
			fade_vld_q  <= 1'b0;
			amb_time_q  <= 32'd0;
			amb_vld_q   <= 1'b0;
		end else begin
			if (item.ready)
				vld_s1 <= item.valid;
			if (advance)
				vld_s2 <= vld_s1;
			if (cfg_we) begin
				case (cfg_index)
					bdac_pkg::CFG_AUTO_ENABLE:
						auto_en_q <= cfg_wdata[0];
					bdac_pkg::CFG_DIM_TIMEOUT_S:
						dim_ms_q <= bdac_pkg::DIM_MS_W'(cfg_wdata) *
						            bdac_pkg::DIM_MS_W'(bdac_pkg::MS_PER_S);
					bdac_pkg::CFG_FADE_STEP_MS:
						// zero selects the default step
						fade_step_q <= (cfg_wdata != '0) ? cfg_wdata
						                                 : bdac_pkg::FADE_DEFAULT_MS;
					bdac_pkg::CFG_START_BRIGHTNESS:
						start_bri_q <= cfg_wdata[7:0];
					default: ;
				endcase
			end
			if (retire) begin
				mode_q      <= mode_nxt;
				bright_q    <= bright_nxt;
				saved_q     <= saved_nxt;
				goal_q      <= goal_nxt;
				dim_q       <= dim_nxt;
				act_time_q  <= act_time_nxt;
				fade_time_q <= fade_time_nxt;
				fade_vld_q  <= fade_vld_nxt;
				amb_time_q  <= amb_time_nxt;
				amb_vld_q   <= amb_vld_nxt;
			end
		end
	end

	// Payload registers and table read
	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			op_s1     <= item.data.opcode;
			now_s1    <= item.data.now_ms;
			luxv_s1   <= item.data.lux_valid;
			lux_lo_s1 <= (item.data.lux <= 16'(bdac_pkg::LUX_LOW));
			lux_hi_s1 <= (item.data.lux >= 16'(bdac_pkg::LUX_HIGH)) ||
			             ({1'b0, item.data.lux} >= 17'(LUX_ROM_DEPTH));
			rom_s1    <= lux_rom[item.data.lux[ROM_AW-1:0]];
		end
		if (retire)
			res_s2 <= res_nxt;
	end

`ifndef NO_ASSERTIONS
	// undimming only runs with the dim flag clear
	a_undim_not_dimmed: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.mode_now == bdac_pkg::MODE_UNDIMMING
			|-> !result.data.dimmed)
		else $error("undimming reported while dimmed");

	// brightness only moves when an item retires
	a_bright_on_retire: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(bright_q) |-> $past(retire))
		else $error("brightness changed without an item");

	// dim flag is only set from the dimming mode
	a_dim_from_dimming: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dim_q) |-> $past(mode_q) == bdac_pkg::MODE_DIMMING)
		else $error("dim flag set outside dimming");

	// fade timer only starts in a fading mode
	a_fade_from_fading: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fade_vld_q) |-> ($past(mode_q) == bdac_pkg::MODE_DIMMING) ||
		                      ($past(mode_q) == bdac_pkg::MODE_UNDIMMING))
		else $error("fade timer started while awake");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_backlight_dim_ambient_controller.sv =====
`timescale 1ns / 1ps
// Self-checking bench for backlight_dim_ambient_controller: timestamped words in,
// one status word out each, scored against a built-in predictor of the controller.
// Depends on bdac_pkg, bdac_in_if and bdac_out_if from the RTL.

module tb_backlight_dim_ambient_controller;
	import bdac_pkg::*;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         STALL_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	bdac_in_if  in_ch();
	bdac_out_if out_ch();

	backlight_dim_ambient_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.item      (in_ch),
		.result    (out_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predictor state: configuration copy and controller state
	logic        auto_on;
	logic [15:0] tmo_s;
	logic [15:0] step_ms;
	logic [7:0]  start_lvl;
	mode_t       bl_mode;
	logic [7:0]  bl_level;
	logic [7:0]  bl_saved;
	logic [7:0]  bl_goal;
	logic        bl_dimmed;
	logic [31:0] act_ms;
	logic [31:0] fade_ms;
	logic [31:0] glide_ms;
	logic        fade_armed;
	logic        glide_armed;
	logic [7:0]  lux_map [0:LUX_ROM_DEPTH_DEF-1];

	result_t     predicted_status [$];

	// Stimulus and bookkeeping
	logic [31:0] now_cursor;
	logic [15:0] lux_now;
	bit          src_gaps_on;
	bit          sink_gaps_on;
	int          hold_req;
	int          hold_seq;
	int          stall_count;
	int          n_words;
	int          n_status = 0;
	int          n_errors = 0;
	int          n_writes;
	int          n_dims;
	int          n_wakes;
	int          n_holds = 0;
	int          n_settings;

	// log2 in unsigned Q32 by repeated squaring of the normalized mantissa
	function automatic logic [63:0] log2_q32(input logic [31:0] x);
		logic [63:0] mant;
		logic [63:0] acc;
		int          msb;
		int          b;
		msb = 0;
		while (msb < 12 && (x >> (msb + 1)) != 32'd0)
			msb++;
		mant = (64'(x) << 31) >> msb;
		acc  = 64'(msb) << 32;
		for (b = 31; b >= 0; b--) begin
			mant = (mant * mant) >> 31;
			if (mant >= 64'h1_0000_0000) begin
				mant   = mant >> 1;
				acc[b] = 1'b1;
			end
		end
		return acc;
	endfunction

	task automatic build_lux_map();
		logic [63:0] ten;
		logic [63:0] q;
		int          i;
		ten = log2_q32(32'd10);
		for (i = 0; i < LUX_ROM_DEPTH_DEF; i++) begin
			if (i <= LUX_LOW)
				lux_map[i] = BRI_LOW;
			else if (i >= LUX_HIGH)
				lux_map[i] = BRI_HIGH;
			else begin
				q = (64'(BRI_HIGH - BRI_LOW) * log2_q32(32'(i))) / (64'd3 * ten);
				lux_map[i] = BRI_LOW + q[7:0];
			end
		end
	endtask

	task automatic reset_model();
		auto_on     = AUTO_ENABLE_RST;
		tmo_s       = 16'd0;
		step_ms     = FADE_STEP_RST;
		start_lvl   = START_BRIGHTNESS_RST;
		bl_mode     = MODE_AWAKE;
		bl_level    = BRIGHT_RST;
		bl_saved    = SAVED_RST;
		bl_goal     = 8'd0;
		bl_dimmed   = 1'b0;
		act_ms      = 32'd0;
		fade_ms     = 32'd0;
		glide_ms    = 32'd0;
		fade_armed  = 1'b0;
		glide_armed = 1'b0;
	endtask

	function automatic logic [7:0] lux_goal(input logic [15:0] lx);
		if (lx <= LUX_LOW)
			return BRI_LOW;
		if (lx >= LUX_HIGH || lx >= LUX_ROM_DEPTH_DEF)
			return BRI_HIGH;
		return lux_map[lx];
	endfunction

	// Fade timer: steps at once when not armed, else once per step period
	function automatic logic fade_tick(input logic [31:0] now);
		logic [31:0] period;
		logic [31:0] elapsed;
		period  = (step_ms == 16'd0) ? 32'(FADE_DEFAULT_MS) : 32'(step_ms);
		elapsed = now - fade_ms;
		if (fade_armed && elapsed < period)
			return 1'b0;
		fade_armed = 1'b1;
		fade_ms    = now;
		return 1'b1;
	endfunction

	// Ambient glide: once per period, slew-limited move toward the lux target
	function automatic logic glide_step(input item_t w);
		logic [31:0] elapsed;
		logic [7:0]  tgt;
		logic [7:0]  gap;
		if (!auto_on || bl_dimmed)
			return 1'b0;
		elapsed = w.now_ms - glide_ms;
		if (glide_armed && elapsed < AMBIENT_PERIOD_MS_DEF)
			return 1'b0;
		glide_armed = 1'b1;
		glide_ms    = w.now_ms;
		if (!w.lux_valid)
			return 1'b0;
		tgt = lux_goal(w.lux);
		if (tgt == bl_level)
			return 1'b0;
		if (tgt > bl_level) begin
			gap      = tgt - bl_level;
			bl_level = bl_level + ((gap < MAX_SLEW_DEF) ? gap : 8'(MAX_SLEW_DEF));
		end else begin
			gap      = bl_level - tgt;
			bl_level = bl_level - ((gap < MAX_SLEW_DEF) ? gap : 8'(MAX_SLEW_DEF));
		end
		bl_saved = bl_level;
		return 1'b1;
	endfunction

	// Status after one word, updating the predicted controller state
	function automatic result_t step_backlight(input item_t w);
		result_t     st;
		logic        wrote;
		logic        tick;
		logic [31:0] elapsed;
		logic [31:0] tmo_ms;
		wrote = 1'b0;
		case (w.opcode)
			OP_INIT: begin
				wrote       = (bl_level != start_lvl);
				bl_level    = start_lvl;
				bl_saved    = start_lvl;
				bl_goal     = 8'd0;
				bl_dimmed   = 1'b0;
				bl_mode     = MODE_AWAKE;
				act_ms      = w.now_ms;
				fade_armed  = 1'b0;
				glide_armed = 1'b0;
				fade_ms     = 32'd0;
				glide_ms    = 32'd0;
			end
			OP_ACTIVITY: begin
				act_ms = w.now_ms;
				// wake a dimmed or dark panel
				if (bl_dimmed || bl_level == 8'd0) begin
					bl_dimmed  = 1'b0;
					fade_armed = 1'b0;
					bl_goal    = (bl_saved != 8'd0) ? bl_saved : UNDIM_FLOOR;
					bl_mode    = MODE_UNDIMMING;
					n_wakes++;
				end
			end
			OP_POLL: begin
				case (bl_mode)
					MODE_DIMMING: begin
						if (!bl_dimmed) begin
							bl_dimmed  = 1'b1;
							bl_saved   = bl_level;
							fade_armed = 1'b0;
						end
						tick = fade_tick(w.now_ms);
						if (tick && bl_level != 8'd0) begin
							bl_level = bl_level - 8'd1;
							wrote    = 1'b1;
						end
						if (bl_level == 8'd0)
							bl_mode = MODE_AWAKE;
					end
					MODE_UNDIMMING: begin
						tick = fade_tick(w.now_ms);
						if (tick && bl_level < bl_goal) begin
							bl_level = bl_level + 8'd1;
							wrote    = 1'b1;
						end
						if (bl_level >= bl_goal)
							bl_mode = MODE_AWAKE;
					end
					default: begin
						tmo_ms  = 32'(tmo_s) * 32'(MS_PER_S);
						elapsed = w.now_ms - act_ms;
						if (!bl_dimmed && tmo_s != 16'd0 && elapsed >= tmo_ms) begin
							bl_mode = MODE_DIMMING;
							n_dims++;
						end else
							wrote = glide_step(w);
					end
				endcase
			end
			default: ;
		endcase
		if (wrote)
			n_writes++;
		st.level         = bl_level;
		st.level_written = wrote;
		st.mode_now      = bl_mode;
		st.dimmed        = bl_dimmed;
		return st;
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		n_errors++;
		if (n_errors <= 40)
			$display("[%0t] status word %0d: %s is %0d, predicted %0d",
				$time, n_status, what, got, want);
	endtask

	// Offer one word, with an occasional idle burst first; predict on acceptance
	task automatic send_word(input logic [1:0] op, input logic [31:0] now,
			input logic lv, input logic [15:0] lx);
		item_t w;
		w.opcode    = op;
		w.now_ms    = now;
		w.lux_valid = lv;
		w.lux       = lx;
		if (src_gaps_on && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= w;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		predicted_status.push_back(step_backlight(w));
		n_words++;
	endtask

	// Stop offering, wait for every predicted status, then let the pipe settle
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (predicted_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
	endtask

	task automatic configure(input logic a, input logic [15:0] tmo, input logic [15:0] stp,
			input logic [7:0] st);
		drain_results();
		put_reg(CFG_AUTO_ENABLE, 16'(a));
		put_reg(CFG_DIM_TIMEOUT_S, tmo);
		put_reg(CFG_FADE_STEP_MS, stp);
		put_reg(CFG_START_BRIGHTNESS, 16'(st));
		cfg_we    <= 1'b0;
		auto_on   = a;
		tmo_s     = tmo;
		step_ms   = stp;
		start_lvl = st;
		n_settings++;
	endtask

	// Mostly polls on an advancing clock, with some activity, init and noise
	task automatic send_random(input int count, input int unsigned max_adv,
			input int unsigned act_pct);
		logic [1:0]  op;
		logic        lv;
		int unsigned r;
		int          k;
		for (k = 0; k < count; k++) begin
			r = $urandom_range(0, 999);
			if (r < act_pct * 10)
				op = OP_ACTIVITY;
			else if (r < act_pct * 10 + 5)
				op = OP_INIT;
			else if (r < act_pct * 10 + 12)
				op = OP_UNUSED;
			else
				op = OP_POLL;
			r = $urandom_range(0, 99);
			if (r == 0)
				now_cursor = $urandom();
			else if (r == 1)
				now_cursor = 32'hFFFF_FFFF - 32'($urandom_range(0, 2000));
			else if (r < 4)
				now_cursor = now_cursor - 32'($urandom_range(1, 500));
			else
				now_cursor = now_cursor + 32'($urandom_range(0, max_adv));
			// lux holds for stretches so the glide can settle
			r = $urandom_range(0, 99);
			if (r < 6)
				lux_now = 16'($urandom_range(0, 1100));
			else if (r < 8)
				lux_now = 16'($urandom_range(0, 3));
			else if (r < 10)
				lux_now = 16'($urandom_range(0, 65535));
			lv = ($urandom_range(0, 9) != 0);
			send_word(op, now_cursor, lv, lux_now);
		end
	endtask

	// Extremes of the fields, each opcode, never-stepped timers, timestamp wrap
	task automatic test_directed();
		logic [31:0] t0;
		send_word(OP_POLL, 32'd0, 1'b1, 16'hFFFF);
		send_word(OP_UNUSED, 32'hFFFF_FFFF, 1'b0, 16'd0);
		send_word(OP_INIT, 32'd5, 1'b1, 16'd1);
		configure(1'b0, 16'd0, 16'd0, 8'd0);
		send_word(OP_INIT, 32'd100, 1'b0, 16'd0);
		send_word(OP_ACTIVITY, 32'd110, 1'b0, 16'd0);
		send_word(OP_POLL, 32'd120, 1'b0, 16'd0);
		send_word(OP_POLL, 32'd149, 1'b0, 16'd0);
		send_word(OP_POLL, 32'd150, 1'b0, 16'd0);
		send_word(OP_UNUSED, 32'd151, 1'b1, 16'd500);
		send_word(OP_ACTIVITY, 32'd160, 1'b0, 16'd0);
		send_word(OP_POLL, 32'd200, 1'b1, 16'd1000);
		configure(1'b1, 16'd1, 16'hFFFF, 8'd255);
		t0 = 32'hFFFF_FE00;
		send_word(OP_INIT, t0, 1'b0, 16'd0);
		send_word(OP_POLL, t0, 1'b1, 16'd0);
		send_word(OP_POLL, t0 + 32'd999, 1'b1, 16'd999);
		send_word(OP_POLL, t0 + 32'd1000, 1'b1, 16'd2);
		send_word(OP_POLL, t0 + 32'd1001, 1'b1, 16'd1023);
		send_word(OP_POLL, t0 + 32'd1002, 1'b1, 16'd1024);
		send_word(OP_ACTIVITY, t0 + 32'd1003, 1'b0, 16'd0);
		send_word(OP_POLL, t0 + 32'd1004, 1'b0, 16'd0);
		send_word(OP_POLL, t0 + 32'd1500, 1'b0, 16'd1000);
		now_cursor = t0 + 32'd1500;
	endtask

	task automatic test_ambient_glide();
		configure(1'b1, 16'd0, 16'd30, 8'd128);
		send_word(OP_INIT, now_cursor, 1'b0, 16'd0);
		send_random(260, 1400, 3);
	endtask

	task automatic test_dim_fade();
		configure(1'b1, 16'd1, 16'd0, 8'd40);
		send_word(OP_INIT, now_cursor, 1'b0, 16'd0);
		send_random(170, 70, 1);
		configure(1'b0, 16'd1, 16'd7, 8'd25);
		send_word(OP_INIT, now_cursor, 1'b0, 16'd0);
		send_random(150, 40, 1);
	endtask

	// Long receiver hold-off so the block fills, then a full drain before resuming
	task automatic test_backpressure();
		configure(1'b1, 16'hFFFF, 16'd1, 8'd200);
		send_word(OP_INIT, now_cursor, 1'b0, 16'd0);
		hold_req = 200;
		hold_seq++;
		send_random(70, 1200, 5);
		drain_results();
		send_random(50, 1200, 5);
	endtask

	task automatic test_streaming();
		configure(1'b1, 16'd3, 16'd12, 8'd60);
		src_gaps_on  = 1'b0;
		sink_gaps_on = 1'b0;
		send_word(OP_INIT, now_cursor, 1'b0, 16'd0);
		send_random(380, 300, 2);
	endtask

	// Receiver: random stall bursts, plus hold-offs requested by the tests
	initial begin : sink_side
		int stall_left;
		int burst_left;
		int hold_taken;
		stall_left   = 0;
		burst_left   = 0;
		hold_taken   = 0;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_seq != hold_taken) begin
				stall_left = hold_req;
				hold_taken = hold_seq;
				n_holds++;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else if (burst_left > 0) begin
				burst_left--;
				out_ch.ready <= 1'b0;
			end else if (sink_gaps_on && $urandom_range(0, 7) == 0) begin
				burst_left = $urandom_range(0, 11);
				out_ch.ready <= 1'b0;
			end else
				out_ch.ready <= 1'b1;
		end
	end

	// Score each status word against the oldest prediction
	always @(posedge clk) begin : check_status
		result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			n_status++;
			if (predicted_status.size() == 0)
				flag_mismatch("unpredicted word, level", out_ch.data.level, -1);
			else begin
				want = predicted_status.pop_front();
				if (out_ch.data.level !== want.level)
					flag_mismatch("level", out_ch.data.level, want.level);
				if (out_ch.data.level_written !== want.level_written)
					flag_mismatch("level_written", out_ch.data.level_written,
						want.level_written);
				if (out_ch.data.mode_now !== want.mode_now)
					flag_mismatch("mode_now", out_ch.data.mode_now, want.mode_now);
				if (out_ch.data.dimmed !== want.dimmed)
					flag_mismatch("dimmed", out_ch.data.dimmed, want.dimmed);
			end
		end
	end

	// Watchdog: ends the run when no word moves on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			stall_count <= 0;
		else begin
			stall_count <= stall_count + 1;
			if (stall_count >= STALL_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles, %0d predictions pending",
					STALL_LIMIT, predicted_status.size());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = CFG_AUTO_ENABLE;
		cfg_wdata    = '0;
		in_ch.valid  = 1'b0;
		in_ch.data   = '0;
		src_gaps_on  = 1'b1;
		sink_gaps_on = 1'b1;
		hold_req     = 0;
		hold_seq     = 0;
		now_cursor   = 32'd0;
		lux_now      = 16'd300;
		n_words      = 0;
		n_writes     = 0;
		n_dims       = 0;
		n_wakes      = 0;
		n_settings   = 0;
		build_lux_map();
		reset_model();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_ambient_glide();
		test_dim_fade();
		test_backpressure();
		test_streaming();

		drain_results();
		repeat (4) @(posedge clk);
		$display("%0d words in, %0d status words out, %0d level writes, %0d dim starts",
			n_words, n_status, n_writes, n_dims);
		$display("%0d wakes, %0d register settings incl. zero and full-scale, %0d hold-offs",
			n_wakes, n_settings, n_holds);
		if (n_errors == 0 && predicted_status.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
